// ===== sv/ldoa_pkg.sv =====
// ---------------------------------------------------------------------------
// ldoa_pkg: shared types and constants for the lease-based device arbiter
// Operation codes, field widths, reset values and pipeline record types.
// ---------------------------------------------------------------------------
package ldoa_pkg;

    // Field widths fixed by the interface
    localparam int OP_W    = 4;
    localparam int ID_W    = 32;
    localparam int NOTE_W  = 7;
    localparam int RGB_W   = 24;
    localparam int LEASE_W = 20;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int TIME_BITS_DEF     = 48;

    // Lease register value after reset, in ms
    localparam logic [LEASE_W-1:0] LEASE_RESET = LEASE_W'(4000);

    // Operation codes; codes above OP_CLEAR_COLOURS behave as a query
    typedef enum logic [OP_W-1:0] {
        OP_CLAIM         = 4'd0,
        OP_HOLD          = 4'd1,
        OP_RENEW         = 4'd2,
        OP_UNHOLD        = 4'd3,
        OP_RELEASE       = 4'd4,
        OP_QUERY         = 4'd5,
        OP_WRITE_COLOUR  = 4'd6,
        OP_READ_COLOUR   = 4'd7,
        OP_CLEAR_COLOURS = 4'd8
    } op_t;

    // Lock status carried while the colour memory read completes
    typedef struct packed {
        logic            is_owner;
        logic            held_by_other;
        logic [ID_W-1:0] owner_id;
        logic            colour_written;
    } pipe_t;

    // Registered result
    typedef struct packed {
        logic             is_owner;
        logic             held_by_other;
        logic [ID_W-1:0]  owner_id;
        logic             colour_written;
        logic [RGB_W-1:0] colour_out;
    } res_t;

endpackage

// ===== sv/leased_device_ownership_arbiter.sv =====
// ---------------------------------------------------------------------------
// leased_device_ownership_arbiter: lease-based semaphore for one device
// Tracks owner, holder and hold stamp, expires stale holds, and keeps a
// colour table with per-entry written marks.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_       | in        | s_valid / s_ready  | op, requester_id, now_ms,
//           |           |                    | note_index, rgb_value
//  m_       | out       | m_valid / m_ready  | is_owner, held_by_other, owner_id,
//           |           |                    | colour_written, colour_out
//  cfg_     | in        | cfg_we             | cfg_wdata (lease_ms)
//
// One item per cycle sustained while m_ready stays high; a result reaches m_
// through the pipeline stage, which registers the status and the colour
// memory read at the transfer, and then through the output register.
// Reset clears lock state and all written marks together; no sweep.
// A stalled output holds the result; the memory-read stage then fills and
// s_ready drops until m_ready returns.
module leased_device_ownership_arbiter #(
    parameter int TABLE_ENTRIES = ldoa_pkg::TABLE_ENTRIES_DEF,
    parameter int TIME_BITS     = ldoa_pkg::TIME_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [ldoa_pkg::LEASE_W-1:0] cfg_wdata,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ldoa_pkg::OP_W-1:0]    s_op,
    input  logic [ldoa_pkg::ID_W-1:0]    s_requester_id,
    input  logic [TIME_BITS-1:0]         s_now_ms,
    input  logic [ldoa_pkg::NOTE_W-1:0]  s_note_index,
    input  logic [ldoa_pkg::RGB_W-1:0]   s_rgb_value,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_owner,
    output logic                         m_held_by_other,
    output logic [ldoa_pkg::ID_W-1:0]    m_owner_id,
    output logic                         m_colour_written,
    output logic [ldoa_pkg::RGB_W-1:0]   m_colour_out
);
    import ldoa_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = (TIME_BITS > LEASE_W) ? TIME_BITS : LEASE_W;

    // Lock state
    logic [LEASE_W-1:0]   lease_reg;
    logic [ID_W-1:0]      owner_reg, owner_next;
    logic [ID_W-1:0]      holder_reg, holder_next;
    logic [TIME_BITS-1:0] stamp_reg, stamp_next;

    // Colour table: marks in flops, colours in a synchronous memory
    logic [TABLE_ENTRIES-1:0] written_reg, written_next;
    logic [RGB_W-1:0]         colour_mem [TABLE_ENTRIES];
    logic [RGB_W-1:0]         rdata_reg;

    // Pipeline and output registers
    logic  pipe_valid_reg, pipe_valid_next;
    pipe_t pipe_reg, pipe_next;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg;

    logic            accept, advance;
    logic [AW-1:0]   addr;
    logic            in_range;
    logic            expired;
    logic [TIME_BITS-1:0] age;
    logic [ID_W-1:0] holder_op;
    logic            live_other;

    // Handshake
    assign advance = pipe_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !pipe_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign addr     = AW'(s_note_index);
    assign in_range = 32'(s_note_index) < 32'(TABLE_ENTRIES);

    // Lease check against the stored stamp
    assign age     = s_now_ms - stamp_reg;
    assign expired = (s_now_ms >= stamp_reg) && (CW'(age) >= CW'(lease_reg));
    assign live_other = (holder_reg != '0) && (holder_reg != s_requester_id) && !expired;

    // Lock update for the accepted operation
    always_comb begin
        owner_next   = owner_reg;
        holder_op    = holder_reg;
        stamp_next   = stamp_reg;
        written_next = written_reg;
        case (s_op)
            OP_CLAIM: begin
                if (!live_other) begin
                    owner_next = s_requester_id;
                end
            end
            OP_HOLD: begin
                stamp_next = s_now_ms;
                holder_op  = s_requester_id;
                owner_next = s_requester_id;
            end
            OP_RENEW: begin
                if (holder_reg == s_requester_id) begin
                    stamp_next = s_now_ms;
                end
            end
            OP_UNHOLD: begin
                if (holder_reg == s_requester_id) begin
                    holder_op = '0;
                end
            end
            OP_RELEASE: begin
                if (owner_reg == s_requester_id) begin
                    owner_next = '0;
                end
            end
            OP_WRITE_COLOUR: begin
                if (in_range) begin
                    written_next[addr] = 1'b1;
                end
            end
            OP_CLEAR_COLOURS: begin
                written_next = '0;
            end
            default: begin
            end
        endcase
        // Examine the hold for this requester: another's stale hold is dropped.
        // The stamp only changed where the requester is the holder.
        if ((holder_op != '0) && (holder_op != s_requester_id) && expired) begin
            holder_next = '0;
        end else begin
            holder_next = holder_op;
        end
    end

    // Status for the pipeline stage
    always_comb begin
        pipe_next.held_by_other = (holder_next != '0) && (holder_next != s_requester_id);
        if (holder_next != '0) begin
            pipe_next.is_owner = holder_next == s_requester_id;
        end else begin
            pipe_next.is_owner = (owner_next == '0) || (owner_next == s_requester_id);
        end
        pipe_next.owner_id       = owner_next;
        pipe_next.colour_written = (s_op == OP_READ_COLOUR) && in_range && written_reg[addr];
    end

    // Stage valid flags
    always_comb begin
        pipe_valid_next = pipe_valid_reg;
        if (accept) begin
            pipe_valid_next = 1'b1;
        end else if (advance) begin
            pipe_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lease_reg      <= LEASE_RESET;
            owner_reg      <= '0;
            holder_reg     <= '0;
            stamp_reg      <= '0;
            written_reg    <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                lease_reg <= cfg_wdata;
            end
            if (accept) begin
                owner_reg   <= owner_next;
                holder_reg  <= holder_next;
                stamp_reg   <= stamp_next;
                written_reg <= written_next;
            end
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Colour memory: one write or one read per transfer
    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            if (s_op == OP_WRITE_COLOUR) begin
                colour_mem[addr] <= s_rgb_value;
            end
            if (s_op == OP_READ_COLOUR) begin
                rdata_reg <= colour_mem[addr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pipe_reg <= pipe_next;
        end
        if (advance) begin
            out_reg.is_owner       <= pipe_reg.is_owner;
            out_reg.held_by_other  <= pipe_reg.held_by_other;
            out_reg.owner_id       <= pipe_reg.owner_id;
            out_reg.colour_written <= pipe_reg.colour_written;
            out_reg.colour_out     <= pipe_reg.colour_written ? rdata_reg : '0;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_is_owner       = out_reg.is_owner;
    assign m_held_by_other  = out_reg.held_by_other;
    assign m_owner_id       = out_reg.owner_id;
    assign m_colour_written = out_reg.colour_written;
    assign m_colour_out     = out_reg.colour_out;

endmodule

// ===== sv/ldoa_checker.sv =====
// ---------------------------------------------------------------------------
// ldoa_checker: port-level checks for the lease-based device arbiter
// Watches the result channel and is bound to the top level.
// ---------------------------------------------------------------------------
module ldoa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_is_owner,
    input logic                         m_held_by_other,
    input logic [ldoa_pkg::ID_W-1:0]    m_owner_id,
    input logic                         m_colour_written,
    input logic [ldoa_pkg::RGB_W-1:0]   m_colour_out
);
    import ldoa_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_owner_id) && $stable(m_colour_out)
            && $stable(m_is_owner) && $stable(m_held_by_other))
        else $error("result changed while stalled");

    // Another's live hold excludes ownership
    a_hold_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_held_by_other |-> !m_is_owner)
        else $error("owner while another holds");

    // Unmarked entries read as zero
    a_colour_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_colour_written |-> m_colour_out == '0)
        else $error("colour shown without written mark");

endmodule

bind leased_device_ownership_arbiter ldoa_checker u_ldoa_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_is_owner       (m_is_owner),
    .m_held_by_other  (m_held_by_other),
    .m_owner_id       (m_owner_id),
    .m_colour_written (m_colour_written),
    .m_colour_out     (m_colour_out)
);

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: leased_device_ownership_arbiter block test
// Drives lock and color-table requests over the s_ channel and checks every
// m_ transfer against a cycle-free arbiter model here, or a pinned answer.
// A short table of hand-picked requests comes first: reset state, field
// extremes, hold expiry at the lease boundary, time running backwards,
// requester zero and spare op codes. Random phases follow, each under its
// own lease setting, with random idling on both sides. One phase runs with
// no idling and a long receiver hold-off so the block backs up.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ldoa_pkg::*;

    localparam int TIME_W      = TIME_BITS_DEF;
    localparam int ENTRIES     = TABLE_ENTRIES_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 280;
    localparam int CALM_PHASE  = 3;
    localparam int HOLD_OFF    = 150;
    localparam int CYCLE_LIMIT = 200000;

    // Op codes past the last defined one answer like a query
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd9;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

    // Answer when nobody owns or holds the device and no color is read
    localparam res_t UNOWNED = res_t'{1'b1, 1'b0, 32'd0, 1'b0, 24'd0};

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [NOTE_W-1:0] idx;
        logic [RGB_W-1:0]  rgb;
        bit                pinned;
        res_t              want;
    } vector_t;

    // DUT ports
    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_we         = 1'b0;
    logic [LEASE_W-1:0]  cfg_wdata      = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op           = '0;
    logic [ID_W-1:0]     s_requester_id = '0;
    logic [TIME_W-1:0]   s_now_ms       = '0;
    logic [NOTE_W-1:0]   s_note_index   = '0;
    logic [RGB_W-1:0]    s_rgb_value    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_is_owner;
    logic                m_held_by_other;
    logic [ID_W-1:0]     m_owner_id;
    logic                m_colour_written;
    logic [RGB_W-1:0]    m_colour_out;

    // Hand-typed answer that travels with a directed request
    bit                  pin_en  = 1'b0;
    res_t                pin_res = '0;

    // Flow control between the driver and the result sink
    bit                  calm    = 1'b0;
    bit                  squeeze = 1'b0;

    // Arbiter model state
    logic [LEASE_W-1:0]  lease_q;
    logic [ID_W-1:0]     owner_q;
    logic [ID_W-1:0]     holder_q;
    logic [TIME_W-1:0]   stamp_q;
    bit                  mark_q   [ENTRIES];
    logic [RGB_W-1:0]    colour_q [ENTRIES];

    res_t                answer_q[$];
    vector_t             directed_q[$];
    int                  fail_count  = 0;
    int                  cycle_count = 0;

    // Driver-side bookkeeping for random requests
    logic [TIME_W-1:0]   clock_ms  = '0;
    int                  lease_now = 4000;
    bit                  touched_map [ENTRIES];
    int                  touched_q[$];

    leased_device_ownership_arbiter #(
        .TABLE_ENTRIES (ENTRIES),
        .TIME_BITS     (TIME_W)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_requester_id   (s_requester_id),
        .s_now_ms         (s_now_ms),
        .s_note_index     (s_note_index),
        .s_rgb_value      (s_rgb_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_owner       (m_is_owner),
        .m_held_by_other  (m_held_by_other),
        .m_owner_id       (m_owner_id),
        .m_colour_written (m_colour_written),
        .m_colour_out     (m_colour_out)
    );

    always #5ns aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Arbiter model
    // ---------------------------------------------------------------------

    // Live-hold test for a requester; a stale hold of someone else is dropped
    function automatic bit hold_alive(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
        if (holder_q == '0)
            return 1'b0;
        if (holder_q == id)
            return 1'b1;
        if (now >= stamp_q && (now - stamp_q) >= TIME_W'(lease_q)) begin
            holder_q = '0;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Claim fails only while another requester's hold is live
    function automatic void claim_for(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
        if (holder_q != '0 && holder_q != id) begin
            if (hold_alive(id, now))
                return;
        end
        owner_q = id;
    endfunction

    function automatic res_t arbitrate(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] now, logic [NOTE_W-1:0] idx,
                                       logic [RGB_W-1:0] rgb);
        res_t r;
        r = '0;
        case (op)
            OP_CLAIM: begin
                claim_for(id, now);
            end
            OP_HOLD: begin
                stamp_q  = now;
                holder_q = id;
                claim_for(id, now);
            end
            OP_RENEW: begin
                if (holder_q == id)
                    stamp_q = now;
            end
            OP_UNHOLD: begin
                if (holder_q == id)
                    holder_q = '0;
            end
            OP_RELEASE: begin
                if (owner_q == id)
                    owner_q = '0;
            end
            OP_WRITE_COLOUR: begin
                colour_q[idx] = rgb;
                mark_q[idx]   = 1'b1;
            end
            OP_READ_COLOUR: begin
                if (mark_q[idx]) begin
                    r.colour_written = 1'b1;
                    r.colour_out     = colour_q[idx];
                end
            end
            OP_CLEAR_COLOURS: begin
                foreach (mark_q[i])
                    mark_q[i] = 1'b0;
            end
            default: ;
        endcase
        // Every op ends with a look at the hold on behalf of the requester
        void'(hold_alive(id, now));
        r.held_by_other = holder_q != '0 && holder_q != id;
        if (holder_q != '0)
            r.is_owner = holder_q == id;
        else
            r.is_owner = owner_q == '0 || owner_q == id;
        r.owner_id = owner_q;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------
    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        end
    endfunction

    // Model update on each input transfer, compare on each output transfer
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            lease_q  = LEASE_RESET;
            owner_q  = '0;
            holder_q = '0;
            stamp_q  = '0;
            foreach (mark_q[i])
                mark_q[i] = 1'b0;
            answer_q.delete();
        end else begin
            if (cfg_we)
                lease_q = cfg_wdata;
            if (m_valid && m_ready) begin
                got.is_owner       = m_is_owner;
                got.held_by_other  = m_held_by_other;
                got.owner_id       = m_owner_id;
                got.colour_written = m_colour_written;
                got.colour_out     = m_colour_out;
                if (answer_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected: expected nothing, got 0x%0h",
                             $time, got);
                end else begin
                    want = answer_q.pop_front();
                    check_field("is_owner", 64'(want.is_owner), 64'(got.is_owner));
                    check_field("held_by_other", 64'(want.held_by_other),
                                64'(got.held_by_other));
                    check_field("owner_id", 64'(want.owner_id), 64'(got.owner_id));
                    check_field("colour_written", 64'(want.colour_written),
                                64'(got.colour_written));
                    check_field("colour_out", 64'(want.colour_out), 64'(got.colour_out));
                end
            end
            if (s_valid && s_ready) begin
                want = arbitrate(s_op, s_requester_id, s_now_ms, s_note_index, s_rgb_value);
                if (pin_en)
                    want = pin_res;
                answer_q.push_back(want);
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Result sink: random back-pressure plus one long hold-off
    // ---------------------------------------------------------------------
    initial begin
        int  hold_left;
        bit  squeezed;
        hold_left = 0;
        squeezed  = 1'b0;
        forever begin
            @(posedge aclk);
            if (squeeze && !squeezed) begin
                squeezed  = 1'b1;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------------
    task automatic add_row(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] now,
                           logic [NOTE_W-1:0] idx, logic [RGB_W-1:0] rgb, bit pinned,
                           res_t want);
        vector_t v;
        v.op     = op;
        v.id     = id;
        v.now    = now;
        v.idx    = idx;
        v.rgb    = rgb;
        v.pinned = pinned;
        v.want   = want;
        directed_q.push_back(v);
    endtask

    // Offer one request and hold it until the transfer; called at a rising edge
    task automatic offer(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] now,
                         logic [NOTE_W-1:0] idx, logic [RGB_W-1:0] rgb, bit pinned,
                         res_t want);
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_requester_id <= id;
        s_now_ms       <= now;
        s_note_index   <= idx;
        s_rgb_value    <= rgb;
        pin_en         <= pinned;
        pin_res        <= want;
        if (op == OP_WRITE_COLOUR && !touched_map[idx]) begin
            touched_map[idx] = 1'b1;
            touched_q.push_back(int'(idx));
        end
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Stop offering and wait for every outstanding answer plus pipeline slack
    task automatic drain();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (answer_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_lease(int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= LEASE_W'(value);
        lease_now = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly a small set of requesters on a moving clock, so holds meet
    // claims, renewals and expiry; full-range values now and then.
    task automatic random_item();
        int                roll;
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [NOTE_W-1:0] idx;

        roll = $urandom_range(0, 99);
        if (roll < 8)
            clock_ms = TIME_W'({$urandom, $urandom});
        else if (roll < 14)
            clock_ms = clock_ms - TIME_W'($urandom_range(0, lease_now + 1));
        else if (roll >= 34) begin
            if (roll < 50)
                clock_ms = clock_ms + TIME_W'(lease_now - 1 + int'($urandom_range(0, 2)));
            else if (roll < 80)
                clock_ms = clock_ms + TIME_W'($urandom_range(0, lease_now / 4 + 1));
            else
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 2 * lease_now + 1));
        end

        roll = $urandom_range(0, 99);
        if (roll < 70)
            id = ID_W'($urandom_range(1, 3));
        else if (roll < 75)
            id = '1;
        else if (roll < 78)
            id = '0;
        else
            id = ID_W'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 18)
            op = OP_CLAIM;
        else if (roll < 32)
            op = OP_HOLD;
        else if (roll < 44)
            op = OP_RENEW;
        else if (roll < 52)
            op = OP_UNHOLD;
        else if (roll < 62)
            op = OP_RELEASE;
        else if (roll < 68)
            op = OP_QUERY;
        else if (roll < 78)
            op = OP_WRITE_COLOUR;
        else if (roll < 90)
            op = OP_READ_COLOUR;
        else if (roll < 92)
            op = OP_CLEAR_COLOURS;
        else
            op = OP_W'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));

        // Reads only go to entries that have been written at some point
        idx = NOTE_W'($urandom_range(0, ENTRIES - 1));
        if (op == OP_READ_COLOUR) begin
            if (touched_q.size() == 0)
                op = OP_WRITE_COLOUR;
            else
                idx = NOTE_W'(touched_q[$urandom_range(0, touched_q.size() - 1)]);
        end

        offer(op, id, clock_ms, idx, RGB_W'($urandom), 1'b0, '0);
    endtask

    initial begin
        int lease_plan [PHASES];
        int lease_val;

        lease_plan = '{1, 1048575, 0, 250, 0, 4000};

        // Directed requests, lease at its reset value
        add_row(OP_QUERY, 32'd1, 48'd0, 7'd0, 24'd0, 1'b1, UNOWNED);
        add_row(OP_WRITE_COLOUR, 32'd5, 48'd0, 7'd0, 24'hFF_FFFF, 1'b1, UNOWNED);
        add_row(OP_WRITE_COLOUR, 32'd5, 48'd0, 7'd127, 24'd0, 1'b1, UNOWNED);
        add_row(OP_READ_COLOUR, 32'd5, 48'd0, 7'd0, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'd0, 1'b1, 24'hFF_FFFF});
        add_row(OP_READ_COLOUR, 32'd5, 48'd0, 7'd127, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'd0, 1'b1, 24'd0});
        add_row(OP_CLAIM, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 7'd0, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 24'd0});
        add_row(OP_QUERY, 32'd1, 48'd0, 7'd0, 24'd0, 1'b1,
                res_t'{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 24'd0});
        // hold by 2, then claims by 3 one ms before and exactly at expiry
        add_row(OP_HOLD, 32'd2, 48'd1000, 7'd0, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'd2, 1'b0, 24'd0});
        add_row(OP_CLAIM, 32'd3, 48'd4999, 7'd0, 24'd0, 1'b1,
                res_t'{1'b0, 1'b1, 32'd2, 1'b0, 24'd0});
        add_row(OP_CLAIM, 32'd3, 48'd5000, 7'd0, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'd3, 1'b0, 24'd0});
        // clock running backwards keeps a hold live
        add_row(OP_HOLD, 32'd4, 48'd100, 7'd0, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'd4, 1'b0, 24'd0});
        add_row(OP_QUERY, 32'd5, 48'd50, 7'd0, 24'd0, 1'b1,
                res_t'{1'b0, 1'b1, 32'd4, 1'b0, 24'd0});
        add_row(OP_RENEW, 32'd5, 48'd200, 7'd0, 24'd0, 1'b0, '0);
        add_row(OP_RENEW, 32'd4, 48'd10000, 7'd0, 24'd0, 1'b0, '0);
        add_row(OP_CLAIM, 32'd6, 48'd13999, 7'd0, 24'd0, 1'b1,
                res_t'{1'b0, 1'b1, 32'd4, 1'b0, 24'd0});
        add_row(OP_UNHOLD, 32'd5, 48'd10000, 7'd0, 24'd0, 1'b0, '0);
        add_row(OP_UNHOLD, 32'd4, 48'd10000, 7'd0, 24'd0, 1'b1,
                res_t'{1'b1, 1'b0, 32'd4, 1'b0, 24'd0});
        add_row(OP_RELEASE, 32'd5, 48'd10000, 7'd0, 24'd0, 1'b1,
                res_t'{1'b0, 1'b0, 32'd4, 1'b0, 24'd0});
        add_row(OP_RELEASE, 32'd4, 48'd10000, 7'd0, 24'd0, 1'b1, UNOWNED);
        add_row(OP_SPARE_LAST, 32'd7, 48'd10000, 7'd0, 24'd0, 1'b1, UNOWNED);
        add_row(OP_CLEAR_COLOURS, 32'd7, 48'd10000, 7'd0, 24'd0, 1'b1, UNOWNED);
        add_row(OP_READ_COLOUR, 32'd7, 48'd10000, 7'd0, 24'd0, 1'b1, UNOWNED);
        // requester zero: claim stores nobody, hold leaves no holder
        add_row(OP_CLAIM, 32'd0, 48'd0, 7'd0, 24'd0, 1'b1, UNOWNED);
        add_row(OP_HOLD, 32'd0, 48'd0, 7'd0, 24'd0, 1'b1, UNOWNED);

        // Hold reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[i])
            offer(directed_q[i].op, directed_q[i].id, directed_q[i].now, directed_q[i].idx,
                  directed_q[i].rgb, directed_q[i].pinned, directed_q[i].want);

        // Random phases, each under its own lease; one runs flat out with a stall
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            lease_val = lease_plan[ph];
            if (ph == 4)
                lease_val = $urandom_range(1, 1048575);
            program_lease(lease_val);
            calm <= (ph == CALM_PHASE);
            if (ph == CALM_PHASE)
                squeeze <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ldoa_pkg.sv
sv/leased_device_ownership_arbiter.sv
sv/ldoa_checker.sv
verif/testbench.sv
